// ===== hdl/ring_tape_turing_machine_top_defines.svh =====
// ----------------------------------------------------------------------------
// Ring tape Turing machine assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef RING_TAPE_TURING_MACHINE_TOP_DEFINES_SVH
`define RING_TAPE_TURING_MACHINE_TOP_DEFINES_SVH

// Check a consequence in the same cycle as its condition.
`define RTTM_ASSERT_NOW(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);

// Check a consequence in the cycle after its condition.
`define RTTM_ASSERT_NEXT(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/rttm_pkg.sv =====
// ----------------------------------------------------------------------------
// Ring tape Turing machine package
// Sizes, command and register codes and the head record type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rttm_pkg;

	localparam int TAPE_MAX    = 1024;
	localparam int HEADS_MAX   = 8;
	localparam int COLORS_MAX  = 16;
	localparam int STATES_MAX  = 2;
	localparam int TABLE_DEPTH = COLORS_MAX * STATES_MAX;

	localparam int POS_W   = $clog2(TAPE_MAX);
	localparam int LEN_W   = $clog2(TAPE_MAX + 1);
	localparam int HEAD_W  = $clog2(HEADS_MAX);
	localparam int TBL_AW  = $clog2(TABLE_DEPTH);
	localparam int COLOR_W = 4;
	localparam int MOVE_W  = 2;
	localparam int RULE_W  = COLOR_W + MOVE_W + 1;

	// Fixed field widths of the command and register interface
	localparam int CMD_W    = 3;
	localparam int INDEX_W  = 10;
	localparam int NCOL_W   = 5;
	localparam int NHEAD_W  = 4;
	localparam int CFG_W    = 11;
	localparam int CFG_IX_W = 3;
	localparam int ENT_W    = NCOL_W + 1;

	localparam logic [CMD_W-1:0] CMD_TABLE   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_WRCELL  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_RDCELL  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_STEP    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RESTART = 3'd4;

	localparam logic [CFG_IX_W-1:0] REG_NUM_COLORS  = 3'd0;
	localparam logic [CFG_IX_W-1:0] REG_TAPE_LENGTH = 3'd1;
	localparam logic [CFG_IX_W-1:0] REG_NUM_HEADS   = 3'd2;
	localparam logic [CFG_IX_W-1:0] REG_START_CELL  = 3'd3;
	localparam logic [CFG_IX_W-1:0] REG_START_DIR   = 3'd4;

	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic             dir;
		logic             st;
	} head_rec_t;

endpackage

`default_nettype wire

// ===== hdl/rttm_ram.sv =====
// ----------------------------------------------------------------------------
// Ring tape Turing machine RAM
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rttm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== hdl/ring_tape_turing_machine_top.sv =====
// ----------------------------------------------------------------------------
// Ring tape Turing machine
// Several heads step over one shared circular tape under a loaded rule table.
// ----------------------------------------------------------------------------
// Usage:
//   A command transaction is taken on a rising edge with start high and busy
//   low; busy stays high while the command is worked. Table and cell writes
//   are done at acceptance and give no result. A cell read passes through
//   the cell read state and then puts its one result on the ports. A step
//   walks the heads in index order, each through a tape read, a rule read
//   and a write back through one shared update path; result k appears on
//   the ports after the write back of head k, last marking the final one.
//   Each result is held for one cycle with result_strobe high; the receiver
//   cannot stall, so nothing waits on it.
//   Restart loads all head records at once and then clears the tape with a
//   sweep over all 1024 cells, one cell per cycle, with busy high. The same sweep
//   runs after reset. Configuration writes through cfg_we are taken at any
//   time but are meant for idle periods. The rule table is undefined until
//   written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "ring_tape_turing_machine_top_defines.svh"

module ring_tape_turing_machine_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [rttm_pkg::CMD_W-1:0]    cmd,
	input  wire logic [rttm_pkg::INDEX_W-1:0]  index,
	input  wire logic [rttm_pkg::COLOR_W-1:0]  color_value,
	input  wire logic [rttm_pkg::MOVE_W-1:0]   move_code,
	input  wire logic                          next_value,
	input  wire logic                          cfg_we,
	input  wire logic [rttm_pkg::CFG_IX_W-1:0] cfg_index,
	input  wire logic [rttm_pkg::CFG_W-1:0]    cfg_data,
	output logic                               result_strobe,
	output logic [rttm_pkg::HEAD_W-1:0]        head_number,
	output logic [rttm_pkg::POS_W-1:0]         head_cell,
	output logic                               head_direction,
	output logic                               head_state,
	output logic [rttm_pkg::COLOR_W-1:0]       written_color,
	output logic [rttm_pkg::COLOR_W-1:0]       cell_color,
	output logic                               last
);

	import rttm_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_CLEAR  = 6'b000010,
		ST_RDCELL = 6'b000100,
		ST_TREAD  = 6'b001000,
		ST_TLOOK  = 6'b010000,
		ST_APPLY  = 6'b100000
	} state_t;

	state_t state_q;

	logic [NCOL_W-1:0]  num_colors_q;
	logic [LEN_W-1:0]   tape_length_q;
	logic [NHEAD_W-1:0] num_heads_q;
	logic [POS_W-1:0]   start_cell_q;
	logic               start_dir_q;

	head_rec_t          head_q [HEADS_MAX];
	logic [HEAD_W-1:0]  hd_q;
	logic [POS_W-1:0]   clr_q;
	logic               rd_ok_q;

	logic               strobe_q;
	logic [HEAD_W-1:0]  head_number_q;
	logic [POS_W-1:0]   head_cell_q;
	logic               head_dir_q;
	logic               head_state_q;
	logic [COLOR_W-1:0] written_q;
	logic [COLOR_W-1:0] cell_color_q;
	logic               last_q;

	logic               accept;
	logic [LEN_W-1:0]   len;
	logic [HEAD_W-1:0]  n_m1;
	logic [POS_W-1:0]   start_pos;
	logic               idx_in_ring;
	head_rec_t          hd;

	logic               tape_we;
	logic [POS_W-1:0]   tape_waddr;
	logic [COLOR_W-1:0] tape_wdata;
	logic [POS_W-1:0]   tape_raddr;
	logic [COLOR_W-1:0] tape_rdata;

	logic               rule_we;
	logic [ENT_W-1:0]   ent_sum;
	logic [RULE_W-1:0]  rule_rdata;

	logic [COLOR_W-1:0] wcol;
	logic [MOVE_W-1:0]  code;
	logic               nst;
	logic               new_dir;
	logic               mdir;
	logic [LEN_W-1:0]   pos_ext;
	logic [POS_W-1:0]   next_pos;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign hd     = head_q[hd_q];

	// Saturate the ring length and head count to their legal ranges
	always_comb begin
		if (tape_length_q == '0) begin
			len = LEN_W'(1);
		end else if (tape_length_q > LEN_W'(TAPE_MAX)) begin
			len = LEN_W'(TAPE_MAX);
		end else begin
			len = tape_length_q;
		end
		if (num_heads_q == '0) begin
			n_m1 = '0;
		end else if (num_heads_q > NHEAD_W'(HEADS_MAX)) begin
			n_m1 = HEAD_W'(HEADS_MAX - 1);
		end else begin
			n_m1 = HEAD_W'(num_heads_q - NHEAD_W'(1));
		end
	end

	assign start_pos   = ({1'b0, start_cell_q} < len) ? start_cell_q : POS_W'(len - LEN_W'(1));
	assign idx_in_ring = ({1'b0, index} < len);

	// Shared update path: decode the rule entry and find the neighbor cell
	assign wcol    = rule_rdata[COLOR_W-1:0];
	assign code    = rule_rdata[COLOR_W+MOVE_W-1:COLOR_W];
	assign nst     = rule_rdata[RULE_W-1];
	assign new_dir = hd.dir ^ code[0];
	assign mdir    = code[1] ? hd.dir : new_dir;
	assign pos_ext = {1'b0, hd.pos};

	always_comb begin
		if (!mdir) begin
			next_pos = (pos_ext + LEN_W'(1) >= len) ? '0 : POS_W'(pos_ext + LEN_W'(1));
		end else if (hd.pos == '0 || pos_ext >= len) begin
			next_pos = POS_W'(len - LEN_W'(1));
		end else begin
			next_pos = hd.pos - POS_W'(1);
		end
	end

	// Tape port steering
	always_comb begin
		tape_we    = 1'b0;
		tape_waddr = index;
		tape_wdata = color_value;
		case (state_q)
			ST_CLEAR: begin
				tape_we    = 1'b1;
				tape_waddr = clr_q;
				tape_wdata = '0;
			end
			ST_IDLE: begin
				tape_we = accept && (cmd == CMD_WRCELL) && idx_in_ring;
			end
			ST_APPLY: begin
				tape_we    = 1'b1;
				tape_waddr = hd.pos;
				tape_wdata = wcol;
			end
			default: begin
				tape_we = 1'b0;
			end
		endcase
	end

	assign tape_raddr = (state_q == ST_TREAD) ? hd.pos : index;

	assign rule_we = accept && (cmd == CMD_TABLE) && (index < INDEX_W'(TABLE_DEPTH));
	assign ent_sum = ENT_W'(tape_rdata) + (hd.st ? ENT_W'(num_colors_q) : ENT_W'(0));

	rttm_ram #(
		.WIDTH(COLOR_W),
		.DEPTH(TAPE_MAX)
	) u_tape (
		.clk   (clk),
		.we    (tape_we),
		.waddr (tape_waddr),
		.wdata (tape_wdata),
		.raddr (tape_raddr),
		.rdata (tape_rdata)
	);

	rttm_ram #(
		.WIDTH(RULE_W),
		.DEPTH(TABLE_DEPTH)
	) u_rule (
		.clk   (clk),
		.we    (rule_we),
		.waddr (index[TBL_AW-1:0]),
		.wdata ({next_value, move_code, color_value}),
		.raddr (ent_sum[TBL_AW-1:0]),
		.rdata (rule_rdata)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_colors_q  <= NCOL_W'(2);
			tape_length_q <= LEN_W'(TAPE_MAX);
			num_heads_q   <= NHEAD_W'(1);
			start_cell_q  <= POS_W'(512);
			start_dir_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NUM_COLORS:  num_colors_q  <= cfg_data[NCOL_W-1:0];
				REG_TAPE_LENGTH: tape_length_q <= cfg_data[LEN_W-1:0];
				REG_NUM_HEADS:   num_heads_q   <= cfg_data[NHEAD_W-1:0];
				REG_START_CELL:  start_cell_q  <= cfg_data[POS_W-1:0];
				REG_START_DIR:   start_dir_q   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			hd_q     <= '0;
			strobe_q <= 1'b0;
			for (int i = 0; i < HEADS_MAX; i++) begin
				head_q[i] <= '0;
			end
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (cmd)
							CMD_RDCELL: begin
								state_q <= ST_RDCELL;
							end
							CMD_STEP: begin
								hd_q    <= '0;
								state_q <= ST_TREAD;
							end
							CMD_RESTART: begin
								for (int i = 0; i < HEADS_MAX; i++) begin
									head_q[i] <= '{pos: start_pos, dir: start_dir_q, st: 1'b0};
								end
								clr_q   <= '0;
								state_q <= ST_CLEAR;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + POS_W'(1);
					if (clr_q == POS_W'(TAPE_MAX - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RDCELL: begin
					strobe_q <= 1'b1;
					state_q  <= ST_IDLE;
				end
				ST_TREAD: begin
					state_q <= ST_TLOOK;
				end
				ST_TLOOK: begin
					state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					head_q[hd_q] <= '{pos: next_pos, dir: new_dir, st: nst};
					strobe_q     <= 1'b1;
					hd_q         <= hd_q + HEAD_W'(1);
					state_q      <= (hd_q == n_m1) ? ST_IDLE : ST_TREAD;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_ok_q <= idx_in_ring;
		end
		if (state_q == ST_RDCELL) begin
			head_number_q <= '0;
			head_cell_q   <= '0;
			head_dir_q    <= 1'b0;
			head_state_q  <= 1'b0;
			written_q     <= '0;
			cell_color_q  <= rd_ok_q ? tape_rdata : '0;
			last_q        <= 1'b1;
		end else if (state_q == ST_APPLY) begin
			head_number_q <= hd_q;
			head_cell_q   <= next_pos;
			head_dir_q    <= new_dir;
			head_state_q  <= nst;
			written_q     <= wcol;
			cell_color_q  <= '0;
			last_q        <= (hd_q == n_m1);
		end
	end

	assign result_strobe  = strobe_q;
	assign head_number    = head_number_q;
	assign head_cell      = head_cell_q;
	assign head_direction = head_dir_q;
	assign head_state     = head_state_q;
	assign written_color  = written_q;
	assign cell_color     = cell_color_q;
	assign last           = last_q;

	`RTTM_ASSERT_NOW(a_strobe_src, result_strobe, ($past(state_q) == ST_APPLY || $past(state_q) == ST_RDCELL), "result without a finished head or cell read")
	`RTTM_ASSERT_NEXT(a_step_busy, accept && (cmd == CMD_STEP), busy, "step transaction did not hold busy")
	`RTTM_ASSERT_NOW(a_head_range, result_strobe && !last, (head_number < n_m1), "non-final result beyond the head count")
	`RTTM_ASSERT_NOW(a_clear_quiet, state_q == ST_CLEAR, !result_strobe, "result during tape clear")

endmodule

`default_nettype wire
